// File: hw/rtl/multi_pattern_string_matcher_top_assert.svh
// assertion macros for the matcher checker
`ifndef MULTI_PATTERN_STRING_MATCHER_TOP_ASSERT_SVH
`define MULTI_PATTERN_STRING_MATCHER_TOP_ASSERT_SVH

// condition in one cycle implies consequence in the next
`define MPSM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("mpsm assertion failed");

// condition implies consequence in the same cycle
`define MPSM_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("mpsm assertion failed");

`endif

// File: hw/rtl/mpsm_pkg.sv
package mpsm_pkg;

  localparam int NODES_DEF      = 4096;
  localparam int ALPHABET_DEF   = 26;
  localparam int COUNT_BITS_DEF = 16;

  localparam int OP_BITS      = 2;
  localparam int SYM_BITS     = 5;
  localparam int IN_DATA_BITS = 8;
  localparam int TOTAL_BITS   = 16;

  localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = '1;

  typedef enum logic [OP_BITS-1:0] {
    OP_ADD   = 2'd0,
    OP_BUILD = 2'd1,
    OP_SCAN  = 2'd2,
    OP_NOP   = 2'd3
  } opcode_e;

endpackage

// File: hw/rtl/mpsm_ram.sv
module mpsm_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/multi_pattern_string_matcher_top.sv
// channel   | dir | tdata                               | tlast     | tuser
// s_axis    | in  | [1:0] opcode, [6:2] symbol, [7] 0   | last      | -
// m_axis    | out | [15:0] match_total                  | text_done | table_full
//
// one item at a time: a pattern symbol reads its child, claiming a new node if none; with
// last set the end count of the node reached is bumped. a text symbol follows its child and
// adds the end counts along its failure chain up to the root or a node counted before; a
// build seeds the root row, then visits each queued node letter by letter.
// after reset a clearing pass zeroes the child, failure and node rams, input held off.
// the next item is taken while a result waits; a stalled result holds the next one back.
module multi_pattern_string_matcher_top #(
  parameter int NODES      = mpsm_pkg::NODES_DEF,
  parameter int ALPHABET   = mpsm_pkg::ALPHABET_DEF,
  parameter int COUNT_BITS = mpsm_pkg::COUNT_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  logic [mpsm_pkg::IN_DATA_BITS-1:0] s_axis_tdata_i,  // opcode, symbol, pad
  input  logic                              s_axis_tlast_i,  // last
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  output logic [mpsm_pkg::TOTAL_BITS-1:0]   m_axis_tdata_o,  // match_total
  output logic                              m_axis_tlast_o,  // text_done
  output logic                              m_axis_tuser_o   // table_full
);

  localparam int NW  = $clog2(NODES);
  localparam int CD  = NODES * ALPHABET;
  localparam int CAW = $clog2(CD);
  localparam int IW  = $clog2(ALPHABET + 1);
  localparam int TB  = mpsm_pkg::TOTAL_BITS;
  localparam int SW  = ((TB > COUNT_BITS) ? TB : COUNT_BITS) + 1;
  localparam int OB  = mpsm_pkg::OP_BITS;
  localparam int SB  = mpsm_pkg::SYM_BITS;

  localparam logic [NW-1:0] ROOT = NW'(1);

  typedef enum logic [15:0] {
    ST_CLR    = 16'h0001,
    ST_IDLE   = 16'h0002,
    ST_P_CHK  = 16'h0004,
    ST_E_RD   = 16'h0008,
    ST_E_WR   = 16'h0010,
    ST_B_ROOT = 16'h0020,
    ST_B_POP  = 16'h0040,
    ST_B_NOW  = 16'h0080,
    ST_B_FL   = 16'h0100,
    ST_B_RC   = 16'h0200,
    ST_B_RF   = 16'h0400,
    ST_B_ACT  = 16'h0800,
    ST_S_WT   = 16'h1000,
    ST_W_RD   = 16'h2000,
    ST_W_CHK  = 16'h4000,
    ST_FIN    = 16'h8000
  } state_e;

  state_e state_q, state_d;

  logic [CAW-1:0]        clr_q, clr_d;
  logic [NW-1:0]         cursor_q, cursor_d;
  logic [NW-1:0]         scan_q, scan_d;
  logic [NW-1:0]         nfree_q, nfree_d;
  logic [TB-1:0]         total_q, total_d;
  logic                  full_q, full_d;
  logic                  drop_q, drop_d;
  logic                  built_q, built_d;
  logic [NW:0]           head_q, head_d;
  logic [NW:0]           tail_q, tail_d;
  logic [IW-1:0]         idx_q, idx_d;
  logic                  ovalid_q, ovalid_d;

  // payload registers
  mpsm_pkg::opcode_e     op_q, op_d;
  logic [SB-1:0]         sym_q, sym_d;
  logic                  last_q, last_d;
  logic [NW-1:0]         now_q, now_d;
  logic [NW-1:0]         fl_q, fl_d;
  logic [NW-1:0]         to_q, to_d;
  logic [TB-1:0]         otot_q, otot_d;
  logic                  olast_q, olast_d;
  logic                  ouser_q, ouser_d;

  // ram ports
  logic                  c_we;
  logic [CAW-1:0]        c_waddr, c_raddr;
  logic [NW-1:0]         c_wdata, c_rdata;
  logic                  f_we;
  logic [NW-1:0]         f_waddr, f_raddr, f_wdata, f_rdata;
  logic                  n_we;
  logic [NW-1:0]         n_waddr, n_raddr;
  logic [COUNT_BITS:0]   n_wdata, n_rdata;
  logic                  q_we;
  logic [NW-1:0]         q_waddr, q_raddr, q_wdata, q_rdata;

  mpsm_pkg::opcode_e     in_op;
  logic [SB-1:0]         in_sym;
  logic                  in_sym_ok;
  logic                  accept, out_free;
  logic [SW-1:0]         sum;
  logic [COUNT_BITS-1:0] endc;
  logic                  done_item;

  function automatic logic [CAW-1:0] caddr(input logic [NW-1:0] n, input logic [IW-1:0] s);
    return CAW'(n) * CAW'(ALPHABET) + CAW'(s);
  endfunction

  assign in_op     = mpsm_pkg::opcode_e'(s_axis_tdata_i[OB-1:0]);
  assign in_sym    = s_axis_tdata_i[OB+SB-1:OB];
  assign in_sym_ok = (SB + 1)'(in_sym) < (SB + 1)'(ALPHABET);
  assign accept    = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free  = !ovalid_q || m_axis_tready_i;
  assign endc      = n_rdata[COUNT_BITS-1:0];
  assign sum       = SW'(total_q) + SW'(endc);
  assign done_item = (op_q == mpsm_pkg::OP_SCAN) && last_q;

  assign s_axis_tready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d  = state_q;
    clr_d    = clr_q;
    cursor_d = cursor_q;
    scan_d   = scan_q;
    nfree_d  = nfree_q;
    total_d  = total_q;
    full_d   = full_q;
    drop_d   = drop_q;
    built_d  = built_q;
    head_d   = head_q;
    tail_d   = tail_q;
    idx_d    = idx_q;
    ovalid_d = ovalid_q && !m_axis_tready_i;
    op_d     = op_q;
    sym_d    = sym_q;
    last_d   = last_q;
    now_d    = now_q;
    fl_d     = fl_q;
    to_d     = to_q;
    otot_d   = otot_q;
    olast_d  = olast_q;
    ouser_d  = ouser_q;

    c_we = 1'b0; c_waddr = '0; c_wdata = '0; c_raddr = '0;
    f_we = 1'b0; f_waddr = '0; f_wdata = '0; f_raddr = '0;
    n_we = 1'b0; n_waddr = '0; n_wdata = '0; n_raddr = '0;
    q_we = 1'b0; q_waddr = '0; q_wdata = '0; q_raddr = '0;

    case (state_q)
      ST_CLR: begin
        c_we    = 1'b1;
        c_waddr = clr_q;
        if (clr_q < CAW'(NODES)) begin
          f_we    = 1'b1;
          f_waddr = clr_q[NW-1:0];
          n_we    = 1'b1;
          n_waddr = clr_q[NW-1:0];
        end
        clr_d = clr_q + CAW'(1);
        if (clr_q == CAW'(CD - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          op_d   = in_op;
          sym_d  = in_sym;
          last_d = s_axis_tlast_i;
          case (in_op)
            mpsm_pkg::OP_ADD: begin
              c_raddr = caddr(cursor_q, IW'(in_sym));
              if (!drop_q && in_sym_ok) begin
                state_d = ST_P_CHK;
              end else if (s_axis_tlast_i) begin
                state_d = ST_E_RD;
              end else begin
                state_d = ST_FIN;
              end
            end
            mpsm_pkg::OP_BUILD: begin
              idx_d = '0;
              if (built_q) begin
                state_d = ST_FIN;
              end else begin
                built_d = 1'b1;
                state_d = ST_B_ROOT;
              end
            end
            mpsm_pkg::OP_SCAN: begin
              c_raddr = caddr(scan_q, IW'(in_sym));
              state_d = in_sym_ok ? ST_S_WT : ST_FIN;
            end
            default: state_d = ST_FIN;
          endcase
        end
      end
      ST_P_CHK: begin
        if (c_rdata == '0) begin
          if (nfree_q < NW'(NODES - 1)) begin
            nfree_d  = nfree_q + NW'(1);
            c_we     = 1'b1;
            c_waddr  = caddr(cursor_q, IW'(sym_q));
            c_wdata  = nfree_q + NW'(1);
            cursor_d = nfree_q + NW'(1);
          end else begin
            full_d = 1'b1;
            drop_d = 1'b1;
          end
        end else begin
          cursor_d = c_rdata;
        end
        state_d = last_q ? ST_E_RD : ST_FIN;
      end
      ST_E_RD: begin
        n_raddr = cursor_q;
        state_d = ST_E_WR;
      end
      ST_E_WR: begin
        if (!drop_q && endc != '1) begin
          n_we    = 1'b1;
          n_waddr = cursor_q;
          n_wdata = {n_rdata[COUNT_BITS], endc + COUNT_BITS'(1)};
        end
        cursor_d = ROOT;
        drop_d   = 1'b0;
        state_d  = ST_FIN;
      end
      ST_B_ROOT: begin
        // virtual node above the root leads back to the root on every letter
        c_we    = 1'b1;
        c_waddr = caddr('0, idx_q);
        c_wdata = ROOT;
        q_we    = 1'b1;
        q_wdata = ROOT;
        idx_d   = idx_q + IW'(1);
        if (idx_q == IW'(ALPHABET - 1)) begin
          head_d  = '0;
          tail_d  = (NW + 1)'(1);
          state_d = ST_B_POP;
        end
      end
      ST_B_POP: begin
        q_raddr = head_q[NW-1:0];
        if (head_q == tail_q) begin
          state_d = ST_FIN;
        end else begin
          head_d  = head_q + (NW + 1)'(1);
          state_d = ST_B_NOW;
        end
      end
      ST_B_NOW: begin
        now_d   = q_rdata;
        f_raddr = q_rdata;
        state_d = ST_B_FL;
      end
      ST_B_FL: begin
        fl_d    = f_rdata;
        idx_d   = '0;
        state_d = ST_B_RC;
      end
      ST_B_RC: begin
        c_raddr = caddr(now_q, idx_q);
        state_d = ST_B_RF;
      end
      ST_B_RF: begin
        c_raddr = caddr(fl_q, idx_q);
        to_d    = c_rdata;
        state_d = ST_B_ACT;
      end
      ST_B_ACT: begin
        if (to_q == '0) begin
          // missing child becomes the transition of the failure node
          c_we    = 1'b1;
          c_waddr = caddr(now_q, idx_q);
          c_wdata = c_rdata;
        end else begin
          f_we    = 1'b1;
          f_waddr = to_q;
          f_wdata = c_rdata;
          if (tail_q < (NW + 1)'(NODES)) begin
            q_we    = 1'b1;
            q_waddr = tail_q[NW-1:0];
            q_wdata = to_q;
            tail_d  = tail_q + (NW + 1)'(1);
          end
        end
        idx_d   = idx_q + IW'(1);
        state_d = (idx_q == IW'(ALPHABET - 1)) ? ST_B_POP : ST_B_RC;
      end
      ST_S_WT: begin
        to_d    = c_rdata;
        scan_d  = c_rdata;
        state_d = ST_W_RD;
      end
      ST_W_RD: begin
        f_raddr = to_q;
        n_raddr = to_q;
        state_d = (to_q > ROOT) ? ST_W_CHK : ST_FIN;
      end
      ST_W_CHK: begin
        if (n_rdata[COUNT_BITS]) begin
          state_d = ST_FIN;
        end else begin
          total_d = (sum > SW'(mpsm_pkg::TOTAL_MAX)) ? mpsm_pkg::TOTAL_MAX : sum[TB-1:0];
          n_we    = 1'b1;
          n_waddr = to_q;
          n_wdata = {1'b1, endc};
          to_d    = f_rdata;
          state_d = ST_W_RD;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          ovalid_d = 1'b1;
          otot_d   = total_q;
          olast_d  = done_item;
          ouser_d  = full_q;
          if (done_item) begin
            total_d = '0;
            scan_d  = ROOT;
          end
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLR;
      clr_q    <= '0;
      cursor_q <= ROOT;
      scan_q   <= ROOT;
      nfree_q  <= NW'(1);
      total_q  <= '0;
      full_q   <= 1'b0;
      drop_q   <= 1'b0;
      built_q  <= 1'b0;
      head_q   <= '0;
      tail_q   <= '0;
      idx_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      cursor_q <= cursor_d;
      scan_q   <= scan_d;
      nfree_q  <= nfree_d;
      total_q  <= total_d;
      full_q   <= full_d;
      drop_q   <= drop_d;
      built_q  <= built_d;
      head_q   <= head_d;
      tail_q   <= tail_d;
      idx_q    <= idx_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    sym_q   <= sym_d;
    last_q  <= last_d;
    now_q   <= now_d;
    fl_q    <= fl_d;
    to_q    <= to_d;
    otot_q  <= otot_d;
    olast_q <= olast_d;
    ouser_q <= ouser_d;
  end

  mpsm_ram #(.WIDTH(NW), .DEPTH(CD)) u_child_ram (
    .clk_i   (clk_i),
    .we_i    (c_we),
    .waddr_i (c_waddr),
    .wdata_i (c_wdata),
    .raddr_i (c_raddr),
    .rdata_o (c_rdata)
  );

  mpsm_ram #(.WIDTH(NW), .DEPTH(NODES)) u_fail_ram (
    .clk_i   (clk_i),
    .we_i    (f_we),
    .waddr_i (f_waddr),
    .wdata_i (f_wdata),
    .raddr_i (f_raddr),
    .rdata_o (f_rdata)
  );

  // counted mark on top of the end count
  mpsm_ram #(.WIDTH(COUNT_BITS + 1), .DEPTH(NODES)) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (n_we),
    .waddr_i (n_waddr),
    .wdata_i (n_wdata),
    .raddr_i (n_raddr),
    .rdata_o (n_rdata)
  );

  mpsm_ram #(.WIDTH(NW), .DEPTH(NODES)) u_queue_ram (
    .clk_i   (clk_i),
    .we_i    (q_we),
    .waddr_i (q_waddr),
    .wdata_i (q_wdata),
    .raddr_i (q_raddr),
    .rdata_o (q_rdata)
  );

  assign m_axis_tvalid_o = ovalid_q;
  assign m_axis_tdata_o  = otot_q;
  assign m_axis_tlast_o  = olast_q;
  assign m_axis_tuser_o  = ouser_q;

endmodule

// File: hw/rtl/mpsm_checker.sv
`include "multi_pattern_string_matcher_top_assert.svh"

module mpsm_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              s_axis_tvalid_i,
  input logic                              s_axis_tready_o,
  input logic [mpsm_pkg::IN_DATA_BITS-1:0] s_axis_tdata_i,
  input logic                              s_axis_tlast_i,
  input logic                              m_axis_tvalid_o,
  input logic                              m_axis_tready_i,
  input logic [mpsm_pkg::TOTAL_BITS-1:0]   m_axis_tdata_o,
  input logic                              m_axis_tlast_o,
  input logic                              m_axis_tuser_o
);

  // a stalled result stays offered
  `MPSM_ASSERT_NEXT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o)

  // a result is withdrawn only by a transfer
  `MPSM_ASSERT_SAME(a_out_fall, $fell(m_axis_tvalid_o), $past(m_axis_tready_i))

  // full flag never goes back once shown
  `MPSM_ASSERT_NEXT(a_full_sticky, m_axis_tvalid_o && m_axis_tuser_o, m_axis_tuser_o)

  // one item in flight: no back-to-back input transfers
  `MPSM_ASSERT_NEXT(a_one_item, s_axis_tvalid_i && s_axis_tready_o, !s_axis_tready_o)

endmodule

bind multi_pattern_string_matcher_top mpsm_checker u_mpsm_checker (.*);

// File: tb/tb_multi_pattern_string_matcher_top.sv
`timescale 1ns / 100ps

module tb_multi_pattern_string_matcher_top;

  localparam int NODES    = mpsm_pkg::NODES_DEF;
  localparam int ALPH     = mpsm_pkg::ALPHABET_DEF;
  localparam int CNT_MAX  = (1 << mpsm_pkg::COUNT_BITS_DEF) - 1;
  localparam int IDLE_MAX = 1000000;

  typedef struct packed {
    logic [15:0] total;
    logic        done;
    logic        full;
  } match_res_t;

  typedef struct {
    mpsm_pkg::opcode_e op;
    logic [4:0]        sym;
    logic              lst;
    bit                typed;
    match_res_t        res;
  } row_t;

  logic                              clk_i;
  logic                              rst_ni;
  logic                              s_axis_tvalid_i;
  logic                              s_axis_tready_o;
  logic [mpsm_pkg::IN_DATA_BITS-1:0] s_axis_tdata_i;
  logic                              s_axis_tlast_i;
  logic                              m_axis_tvalid_o;
  logic                              m_axis_tready_i;
  logic [mpsm_pkg::TOTAL_BITS-1:0]   m_axis_tdata_o;
  logic                              m_axis_tlast_o;
  logic                              m_axis_tuser_o;

  multi_pattern_string_matcher_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tlast_i (s_axis_tlast_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  // shadow copy of the automaton
  bit [11:0] trie_child [NODES*ALPH];
  bit [11:0] fail_link [NODES];
  bit [15:0] end_cnt [NODES];
  bit        counted [NODES];
  int        free_top = 1;
  int        ins_node = 1;
  int        scan_at = 1;
  int        text_total = 0;
  bit        full_seen = 0;
  bit        dropping = 0;
  bit        links_built = 0;

  match_res_t pending_matches[$];
  row_t       stim_rows[$];
  string      word_bank[$];
  int         errors = 0;
  int         idle_cycles = 0;
  int         burst_left = 0;

  function automatic void build_failure_links();
    int bfs[$];
    int now, fl, to;
    if (links_built) return;
    links_built = 1;
    for (int i = 0; i < ALPH; i++) trie_child[i] = 1;
    fail_link[1] = 0;
    bfs.push_back(1);
    while (bfs.size() > 0) begin
      now = bfs.pop_front();
      fl  = fail_link[now];
      for (int i = 0; i < ALPH; i++) begin
        to = trie_child[now*ALPH+i];
        if (to == 0) begin
          trie_child[now*ALPH+i] = trie_child[fl*ALPH+i];
        end else begin
          fail_link[to] = trie_child[fl*ALPH+i];
          bfs.push_back(to);
        end
      end
    end
  endfunction

  function automatic match_res_t predict_match(mpsm_pkg::opcode_e op, logic [4:0] sym,
                                               logic lst);
    match_res_t r;
    int c, to;
    bit done;
    done = 0;
    case (op)
      mpsm_pkg::OP_ADD: begin
        if (!dropping && sym < ALPH) begin
          c = trie_child[ins_node*ALPH+sym];
          if (c == 0) begin
            if (free_top < NODES-1) begin
              free_top++;
              trie_child[ins_node*ALPH+sym] = free_top;
              c = free_top;
            end else begin
              full_seen = 1;
              dropping  = 1;
            end
          end
          if (!dropping) ins_node = c;
        end
        if (lst) begin
          if (!dropping && end_cnt[ins_node] < CNT_MAX) end_cnt[ins_node]++;
          ins_node = 1;
          dropping = 0;
        end
      end
      mpsm_pkg::OP_BUILD: build_failure_links();
      mpsm_pkg::OP_SCAN: begin
        if (sym < ALPH) begin
          to = trie_child[scan_at*ALPH+sym];
          scan_at = to;
          while (to > 1 && !counted[to]) begin
            text_total += end_cnt[to];
            if (text_total > 65535) text_total = 65535;
            counted[to] = 1;
            to = fail_link[to];
          end
        end
        done = lst;
      end
      default: ;
    endcase
    r.total = text_total[15:0];
    r.done  = done;
    r.full  = full_seen;
    if (done) begin
      text_total = 0;
      scan_at    = 1;
    end
    return r;
  endfunction

  function automatic void add_row(mpsm_pkg::opcode_e op, logic [4:0] sym, logic lst,
                                  bit typed = 0, match_res_t res = '0);
    row_t r;
    r.op = op; r.sym = sym; r.lst = lst; r.typed = typed; r.res = res;
    stim_rows.push_back(r);
  endfunction

  function automatic void add_word(mpsm_pkg::opcode_e op, string w, bit lst = 1);
    for (int i = 0; i < w.len(); i++)
      add_row(op, 5'(w[i] - 8'd97), lst && (i == w.len()-1));
  endfunction

  // drives one transfer, with a random gap whenever a burst runs out
  task automatic send_item(row_t r);
    int gap;
    match_res_t p;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        s_axis_tvalid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {1'b0, r.sym, r.op};
    s_axis_tlast_i  <= r.lst;
    forever begin
      @(posedge clk_i);
      if (s_axis_tready_o) break;
    end
    idle_cycles = 0;
    p = predict_match(r.op, r.sym, r.lst);
    pending_matches.push_back(r.typed ? r.res : p);
  endtask

  task automatic send_random_text();
    int n;
    string w;
    n = $urandom_range(1, 5);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 2) != 0 && word_bank.size() > 0) begin
        w = word_bank[$urandom_range(0, word_bank.size()-1)];
        for (int i = 0; i < w.len(); i++)
          send_item('{mpsm_pkg::OP_SCAN, 5'(w[i] - 8'd97), 1'b0, 1'b0, '0});
      end else begin
        send_item('{mpsm_pkg::OP_SCAN, 5'($urandom_range(0, 31)), 1'b0, 1'b0, '0});
      end
    end
    send_item('{mpsm_pkg::OP_SCAN, 5'($urandom_range(0, ALPH-1)), 1'b1, 1'b0, '0});
  endtask

  function automatic string random_word(int len, int letters);
    string s;
    s = "";
    for (int i = 0; i < len; i++) s = {s, string'(8'd97 + 8'($urandom_range(0, letters-1)))};
    return s;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // result side: ready follows a random bit pattern, sometimes held high
  logic [15:0] stall_pat;
  int          stall_left = 0;
  int          stall_ph = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
      stall_pat  <= '1;
    end else begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        idle_cycles = 0;
        if (pending_matches.size() == 0) begin
          errors++;
          $display("%0t: unexpected transfer, actual total %0d done %0b full %0b", $time,
                   m_axis_tdata_o, m_axis_tlast_o, m_axis_tuser_o);
        end else begin
          match_res_t e;
          e = pending_matches.pop_front();
          if (e.total !== m_axis_tdata_o || e.done !== m_axis_tlast_o ||
              e.full !== m_axis_tuser_o) begin
            errors++;
            $display("%0t: mismatch, expected total %0d done %0b full %0b, actual %0d %0b %0b",
                     $time, e.total, e.done, e.full, m_axis_tdata_o, m_axis_tlast_o,
                     m_axis_tuser_o);
          end
        end
      end
      if (stall_left == 0) begin
        stall_left <= $urandom_range(8, 64);
        stall_pat  <= ($urandom_range(0, 3) == 0) ? 16'hffff : 16'($urandom);
      end else begin
        stall_left <= stall_left - 1;
      end
      stall_ph <= stall_ph + 1;
      m_axis_tready_i <= stall_pat[stall_ph % 16];
    end
  end

  initial begin
    forever begin
      @(posedge clk_i);
      idle_cycles++;
      if (idle_cycles >= IDLE_MAX) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    int r;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tlast_i  = 1'b0;
    rst_ni          = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // before any build: nothing can match, out-of-range and idle opcodes
    add_row(mpsm_pkg::OP_NOP, 5'd31, 1'b1, 1, '{16'd0, 1'b0, 1'b0});
    add_row(mpsm_pkg::OP_SCAN, 5'd0, 1'b0, 1, '{16'd0, 1'b0, 1'b0});
    add_row(mpsm_pkg::OP_SCAN, 5'd31, 1'b1, 1, '{16'd0, 1'b1, 1'b0});
    add_row(mpsm_pkg::OP_SCAN, 5'd25, 1'b1, 1, '{16'd0, 1'b1, 1'b0});
    add_word(mpsm_pkg::OP_ADD, "he");
    add_word(mpsm_pkg::OP_ADD, "she");
    add_word(mpsm_pkg::OP_ADD, "his");
    add_word(mpsm_pkg::OP_ADD, "hers");
    add_word(mpsm_pkg::OP_ADD, "he");
    add_row(mpsm_pkg::OP_ADD, 5'd31, 1'b1);
    add_row(mpsm_pkg::OP_ADD, 5'd26, 1'b0);
    add_word(mpsm_pkg::OP_ADD, "z");
    add_word(mpsm_pkg::OP_SCAN, "she");
    foreach (stim_rows[i]) send_item(stim_rows[i]);
    word_bank = '{"he", "she", "his", "hers", "z"};

    // grow the trie with a few long random patterns
    for (int k = 0; k < 4; k++) begin
      string w;
      w = random_word($urandom_range(20, 30), ALPH);
      for (int i = 0; i < w.len(); i++)
        send_item('{mpsm_pkg::OP_ADD, 5'(w[i] - 8'd97), i == w.len()-1, 1'b0, '0});
    end

    send_item('{mpsm_pkg::OP_BUILD, 5'd0, 1'b0, 1'b0, '0});
    send_item('{mpsm_pkg::OP_BUILD, 5'd31, 1'b1, 1'b0, '0});
    stim_rows.delete();
    add_word(mpsm_pkg::OP_SCAN, "ushers");
    add_word(mpsm_pkg::OP_SCAN, "ahishers");
    foreach (stim_rows[i]) send_item(stim_rows[i]);

    // random mix, mostly texts built from known patterns
    for (int n = 0; n < 60; n++) begin
      r = $urandom_range(0, 19);
      if (r < 14) begin
        send_random_text();
      end else if (r < 17) begin
        string w;
        w = random_word($urandom_range(1, 4), 6);
        add_word(mpsm_pkg::OP_ADD, w);
        stim_rows.delete();
        add_word(mpsm_pkg::OP_ADD, w);
        foreach (stim_rows[i]) send_item(stim_rows[i]);
        if (word_bank.size() < 24) word_bank.push_back(w);
      end else begin
        send_item('{mpsm_pkg::opcode_e'($urandom_range(0, 3)), 5'($urandom_range(0, 31)),
                    1'($urandom_range(0, 1)), 1'b0, '0});
      end
    end

    s_axis_tvalid_i <= 1'b0;
    while (pending_matches.size() > 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (errors == 0 && pending_matches.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/mpsm_pkg.sv
hw/rtl/mpsm_ram.sv
hw/rtl/multi_pattern_string_matcher_top.sv
hw/rtl/mpsm_checker.sv
tb/tb_multi_pattern_string_matcher_top.sv
